/* rtl/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg
// Types and constants shared by the cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned Buckets        = 1024;
  localparam int unsigned SlotsPerBucket = 4;
  localparam int unsigned FpBits         = 16;
  localparam int unsigned BucketW        = $clog2(Buckets);
  localparam int unsigned SlotW          = (SlotsPerBucket > 1) ? $clog2(SlotsPerBucket) : 1;
  localparam int unsigned SlotSelW       = $clog2(SlotsPerBucket + 1);
  localparam int unsigned TableDepth     = Buckets * SlotsPerBucket;
  localparam int unsigned AddrW          = $clog2(TableDepth);
  localparam int unsigned LineW          = FpBits * SlotsPerBucket;

  localparam logic [31:0] LfsrMask = 32'h8020_0003;
  localparam logic [31:0] MurC1    = 32'hcc9e_2d51;
  localparam logic [31:0] MurC2    = 32'h1b87_3593;
  localparam logic [31:0] MurN     = 32'he654_6b64;
  localparam logic [31:0] MurF1    = 32'h85eb_ca6b;
  localparam logic [31:0] MurF2    = 32'hc2b2_ae35;
  localparam logic [31:0] HashMul  = 32'd900;

  typedef enum logic [1:0] {
    REQ_CONTAINS = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_SPARE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_SPARE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_HASH_SEED   = 2'd0,
    CFG_MAX_KICKS   = 2'd1,
    CFG_RANDOM_SEED = 2'd2,
    CFG_SPARE       = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD_HOME, S_RD_ALT, S_DECIDE,
    S_P_HASH, S_P_RDH, S_P_RDA, S_P_DO, S_P_KICK, S_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [FpBits-1:0] fp;
    logic [BucketW-1:0] home;
  } hash_req_t;

  typedef struct packed {
    logic               done;
    logic [BucketW-1:0] alt;
  } hash_rsp_t;

endpackage

/* rtl/cfe_ram.sv */
// ----------------------------------------------------------------------------
// cfe_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/cfe_hash.sv */
// ----------------------------------------------------------------------------
// cfe_hash
// Alternate bucket unit: two murmur passes, one multiply per cycle.
// ----------------------------------------------------------------------------
module cfe_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        seed_i,
  input  cfe_pkg::hash_req_t req_i,
  output cfe_pkg::hash_rsp_t rsp_o
);
  import cfe_pkg::*;

  logic [3:0]         step_q, step_d;
  logic               busy_q, busy_d;
  logic [31:0]        k_q, k_d, h_q, h_d, a_q, a_d;
  logic [31:0]        key_q, key_d;
  logic [BucketW-1:0] home_q, home_d;
  logic               pass_q, pass_d;
  logic [31:0]        mul_a, mul_b, prod, hv;

  assign prod = mul_a * mul_b;
  assign hv   = a_q + prod;

  always_comb begin
    mul_a = k_q;
    mul_b = MurC1;
    case (step_q)
      4'd0: begin mul_a = key_q; mul_b = MurC1; end
      4'd1: begin mul_a = {k_q[16:0], k_q[31:17]}; mul_b = MurC2; end
      4'd2: begin mul_a = {h_q[18:0], h_q[31:19]}; mul_b = 32'd5; end
      4'd3: begin mul_a = h_q ^ (h_q >> 16); mul_b = MurF1; end
      4'd4: begin mul_a = h_q ^ (h_q >> 13); mul_b = MurF2; end
      4'd6: begin mul_a = h_q; mul_b = HashMul; end
      default: begin mul_a = k_q; mul_b = MurC1; end
    endcase
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    k_d    = k_q;
    h_d    = h_q;
    a_d    = a_q;
    key_d  = key_q;
    home_d = home_q;
    pass_d = pass_q;
    rsp_o.done = 1'b0;
    rsp_o.alt  = home_q ^ hv[BucketW-1:0];
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = 4'd0;
      key_d  = 32'(req_i.fp);
      home_d = req_i.home;
      h_d    = seed_i;
      pass_d = 1'b0;
    end else if (busy_q) begin
      step_d = step_q + 4'd1;
      case (step_q)
        4'd0: k_d = prod;
        4'd1: h_d = h_q ^ prod;
        4'd2: h_d = (prod + MurN) ^ 32'd4;
        4'd3: h_d = prod;
        4'd4: h_d = prod ^ (prod >> 16);
        4'd5: begin
          if (!pass_q) begin
            a_d    = h_q;
            pass_d = 1'b1;
            step_d = 4'd0;
          end else begin
            step_d = 4'd6;
          end
        end
        4'd6: begin
          rsp_o.done = 1'b1;
          busy_d     = 1'b0;
          step_d     = 4'd0;
        end
        default: step_d = 4'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 4'd0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    h_q    <= h_d;
    a_q    <= a_d;
    key_q  <= key_d;
    home_q <= home_d;
    pass_q <= pass_d;
  end
endmodule

/* rtl/cuckoo_filter_engine.sv */
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Cuckoo filter of 4-slot buckets with one victim register.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tdata {home_bucket, fingerprint}, tuser req_type
// m_axis    out  tvalid/tready      tdata status, tuser victim_held
// cfg       in   cfg_valid/ready    cfg_index, cfg_data
// A lookup passes through the hash unit (two 6-step murmur passes and a
// final multiply), two row reads and a decide step. A placement adds two row
// reads and a place step, each kick a row write, a new hash and the reads
// again, and a victim reinsertion after a remove a hash of the victim before
// its own kicks. After reset a clearing pass writes all 1024 rows to zero;
// no item is taken meanwhile. A waiting result holds the engine.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // fingerprint[15:0], home_bucket[41:32]
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // status[1:0]
  output logic        m_axis_tuser_o,   // victim_held
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cfe_pkg::*;

  state_e state_q, state_d;

  logic [31:0]        hseed_q, hseed_d, lfsr_q, lfsr_d;
  logic [9:0]         maxk_q, maxk_d, kicks_q, kicks_d;
  logic [FpBits-1:0]  vfp_q, vfp_d;
  logic [BucketW-1:0] vhome_q, vhome_d, valt_q, valt_d;
  logic               vvalid_q, vvalid_d;
  logic [1:0]         req_q, req_d;
  logic [FpBits-1:0]  fp_q, fp_d, pfp_q, pfp_d;
  logic [BucketW-1:0] home_q, home_d, alt_q, alt_d, phome_q, phome_d, palt_q, palt_d;
  logic [LineW-1:0]   hrow_q, hrow_d;
  logic               premove_q, premove_d;
  logic [1:0]         status_q, status_d;
  logic               hold_q, hold_d;
  logic [BucketW-1:0] clr_q, clr_d;

  logic               we;
  logic [BucketW-1:0] addr;
  logic [LineW-1:0]   wdata, rdata;
  hash_req_t          hreq;
  hash_rsp_t          hrsp;

  cfe_ram #(.Width(LineW), .Depth(Buckets)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  cfe_hash u_hash (.clk_i, .rst_ni, .seed_i(hseed_q), .req_i(hreq), .rsp_o(hrsp));

  function automatic logic [SlotSelW-1:0] find(logic [LineW-1:0] row, logic [FpBits-1:0] v);
    logic [SlotSelW-1:0] r;
    r = SlotSelW'(SlotsPerBucket);
    for (int i = SlotsPerBucket - 1; i >= 0; i--) begin
      if (row[i*FpBits +: FpBits] == v) r = SlotSelW'(i);
    end
    return r;
  endfunction

  function automatic logic [LineW-1:0] put(logic [LineW-1:0] row, logic [SlotSelW-1:0] s,
                                           logic [FpBits-1:0] v);
    logic [LineW-1:0] r;
    r = row;
    for (int i = 0; i < SlotsPerBucket; i++) begin
      if (s == SlotSelW'(i)) r[i*FpBits +: FpBits] = v;
    end
    return r;
  endfunction

  logic [FpBits-1:0]  in_fp;
  logic [31:0]        l1, l2;
  logic [SlotSelW-1:0] hm, am, he, ae, ks;
  logic                vmatch;
  logic [BucketW-1:0]  krow;
  logic [SlotSelW-1:0] NoSlot;

  assign NoSlot = SlotSelW'(SlotsPerBucket);
  assign in_fp  = (s_axis_tdata_i[FpBits-1:0] == '0) ? FpBits'(1) : s_axis_tdata_i[FpBits-1:0];
  assign l1     = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrMask : 32'd0);
  assign l2     = (l1 >> 1) ^ (l1[0] ? LfsrMask : 32'd0);
  assign hm     = find(hrow_q, fp_q);
  assign am     = find(rdata, fp_q);
  assign he     = find(hrow_q, '0);
  assign ae     = find(rdata, '0);
  assign vmatch = vvalid_q && vfp_q == fp_q && (vhome_q == home_q || valt_q == home_q);
  assign krow   = l1[0] ? palt_q : phome_q;
  assign ks     = {1'b0, l2[SlotW-1:0]};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {6'd0, status_q};
  assign m_axis_tuser_o  = hold_q;

  always_comb begin
    state_d = state_q;
    hseed_d = hseed_q; maxk_d = maxk_q; lfsr_d = lfsr_q; kicks_d = kicks_q;
    vfp_d = vfp_q; vhome_d = vhome_q; valt_d = valt_q; vvalid_d = vvalid_q;
    req_d = req_q; fp_d = fp_q; home_d = home_q; alt_d = alt_q;
    pfp_d = pfp_q; phome_d = phome_q; palt_d = palt_q; hrow_d = hrow_q;
    premove_d = premove_q; status_d = status_q; hold_d = hold_q; clr_d = clr_q;
    we = 1'b0; addr = home_q; wdata = '0;
    hreq.start = 1'b0; hreq.fp = pfp_q; hreq.home = phome_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1; addr = clr_q; clr_d = clr_q + 1'b1;
        if (clr_q == BucketW'(Buckets - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d  = s_axis_tuser_i;
          fp_d   = in_fp;
          home_d = s_axis_tdata_i[32 +: BucketW];
          hreq.start = 1'b1; hreq.fp = in_fp; hreq.home = s_axis_tdata_i[32 +: BucketW];
          state_d = S_HASH;
        end
      end
      S_HASH: if (hrsp.done) begin alt_d = hrsp.alt; state_d = S_RD_HOME; end
      S_RD_HOME: begin addr = home_q; state_d = S_RD_ALT; end
      S_RD_ALT: begin addr = alt_q; hrow_d = rdata; state_d = S_DECIDE; end
      S_DECIDE: begin
        state_d = S_OUT;
        hold_d  = vvalid_q;
        case (req_q)
          REQ_ADD: begin
            if (vmatch || hm != NoSlot || am != NoSlot) status_d = ST_OK;
            else if (vvalid_q) status_d = ST_FULL;
            else begin
              pfp_d = fp_q; phome_d = home_q; palt_d = alt_q; kicks_d = '0;
              premove_d = 1'b0; status_d = ST_OK; state_d = S_P_RDH;
            end
          end
          REQ_REMOVE: begin
            if (hm != NoSlot) begin
              we = 1'b1; addr = home_q; wdata = put(hrow_q, hm, '0);
            end else if (am != NoSlot) begin
              we = 1'b1; addr = alt_q; wdata = put(rdata, am, '0);
            end
            if (!(vmatch || hm != NoSlot || am != NoSlot)) status_d = ST_NOTFOUND;
            else begin
              status_d = ST_OK;
              if (hm == NoSlot && am == NoSlot) begin
                vvalid_d = 1'b0; hold_d = 1'b0;
              end else if (vvalid_q) begin
                vvalid_d = 1'b0;
                pfp_d = vfp_q; phome_d = vhome_q; kicks_d = '0; premove_d = 1'b1;
                hreq.start = 1'b1; hreq.fp = vfp_q; hreq.home = vhome_q;
                state_d = S_P_HASH;
              end
            end
          end
          default: status_d = (vmatch || hm != NoSlot || am != NoSlot) ? ST_OK : ST_NOTFOUND;
        endcase
      end
      S_P_HASH: if (hrsp.done) begin palt_d = hrsp.alt; state_d = S_P_RDH; end
      S_P_RDH: begin addr = phome_q; state_d = S_P_RDA; end
      S_P_RDA: begin addr = palt_q; hrow_d = rdata; state_d = S_P_DO; end
      S_P_DO: begin
        if (he != NoSlot) begin
          we = 1'b1; addr = phome_q; wdata = put(hrow_q, he, pfp_q);
          state_d = S_OUT; hold_d = vvalid_q;
        end else if (ae != NoSlot) begin
          we = 1'b1; addr = palt_q; wdata = put(rdata, ae, pfp_q);
          state_d = S_OUT; hold_d = vvalid_q;
        end else if (kicks_q == maxk_q) begin
          vfp_d = pfp_q; vhome_d = phome_q; valt_d = palt_q; vvalid_d = 1'b1;
          hold_d = 1'b1; state_d = S_OUT;
          if (!premove_q) status_d = ST_FULL;
        end else begin
          lfsr_d = l2;
          phome_d = krow;
          hrow_d = l1[0] ? rdata : hrow_q;
          wdata = '0; addr = krow;
          pfp_d = pfp_q;
          status_d = status_q;
          kicks_d = kicks_q + 10'd1;
          state_d = S_P_KICK;
          alt_d = alt_q;
          hold_d = hold_q;
          palt_d = BucketW'(ks);
        end
      end
      S_P_KICK: begin
        we = 1'b1; addr = phome_q;
        wdata = put(hrow_q, palt_q[SlotSelW-1:0], pfp_q);
        pfp_d = hrow_q[palt_q[SlotW-1:0]*FpBits +: FpBits];
        hreq.start = 1'b1; hreq.fp = hrow_q[palt_q[SlotW-1:0]*FpBits +: FpBits];
        hreq.home = phome_q;
        state_d = S_P_HASH;
      end
      S_OUT: if (m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HASH_SEED:   hseed_d = cfg_data_i;
        CFG_MAX_KICKS:   maxk_d  = cfg_data_i[9:0];
        CFG_RANDOM_SEED: lfsr_d  = (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0;
      hseed_q <= 32'd0; maxk_q <= 10'd500; lfsr_q <= 32'd1;
      vvalid_q <= 1'b0; vfp_q <= '0; vhome_q <= '0; valt_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d;
      hseed_q <= hseed_d; maxk_q <= maxk_d; lfsr_q <= lfsr_d;
      vvalid_q <= vvalid_d; vfp_q <= vfp_d; vhome_q <= vhome_d; valt_q <= valt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kicks_q <= kicks_d; req_q <= req_d; fp_q <= fp_d; home_q <= home_d; alt_q <= alt_d;
    pfp_q <= pfp_d; phome_q <= phome_d; palt_q <= palt_d; hrow_q <= hrow_d;
    premove_q <= premove_d; status_q <= status_d; hold_q <= hold_d;
  end
endmodule

/* rtl/cfe_checker.sv */
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the cuckoo filter engine.
// ----------------------------------------------------------------------------
module cfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o
);
  import cfe_pkg::*;

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o)) else $error("ready while result pending");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != ST_SPARE) else $error("bad status");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] == ST_FULL) |-> m_axis_tuser_o)
    else $error("full without victim");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o) else $error("took two items");
endmodule

bind cuckoo_filter_engine cfe_checker u_cfe_checker (.*);
